// File: hw/rtl/vpc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package vpc_pkg;

	// width of one homogeneous dot product result
	localparam int CW  = 50;
	// projection numerator: |c| << 16 plus half of |w|
	localparam int NAW = CW + 17;

	localparam int FIFO_DEPTH = 4;
	localparam int FPW        = 2;
	localparam int FCW        = 3;

	localparam logic [31:0] ONE_Q16  = 32'h0001_0000;
	localparam logic [31:0] WIN_RST  = 32'd720896;
	localparam logic [31:0] VIEW_RST = 32'd65536;

	typedef enum logic {
		ACT_LOAD  = 1'b0,
		ACT_POINT = 1'b1
	} action_t;

	typedef enum logic [2:0] {
		CFG_WIN_MIN_X  = 3'd0,
		CFG_WIN_MAX_X  = 3'd1,
		CFG_WIN_MIN_Y  = 3'd2,
		CFG_WIN_MAX_Y  = 3'd3,
		CFG_VIEW_MIN_X = 3'd4,
		CFG_VIEW_MAX_X = 3'd5,
		CFG_VIEW_MIN_Y = 3'd6,
		CFG_VIEW_MAX_Y = 3'd7
	} cfg_idx_t;

	typedef struct packed {
		logic [CW-1:0] cx;
		logic [CW-1:0] cy;
		logic [CW-1:0] w;
	} dot_t;

	typedef struct packed {
		logic [31:0] win_min;
		logic [31:0] win_max;
		logic [31:0] view_min;
		logic [31:0] view_max;
	} axis_cfg_t;

endpackage
`default_nettype wire

// File: hw/rtl/vertex_project_to_canvas.sv
`timescale 1ns / 1ps
`default_nettype none
// Projects Q16.16 model points through a stored 4x4 matrix onto canvas pixels.
// Input channel (in_valid / in_stall): action 0 loads coef_value into matrix
// slot coef_index and gives no result; action 1 transforms point_x/y/z.
// Output channel (out_valid / out_stall): one beat per point with canvas_x,
// canvas_y and divide_fault (w was zero, coordinates forced to zero).
// Config port: cfg_we writes cfg_data into window/viewport register cfg_index;
// write only while no point is in flight.
// Throughput: one beat per cycle while in_stall and out_stall stay low, set by
// the pipelined dividers that resolve one quotient bit per stage.
// A four-entry queue parts the multiply front end from the divide back end.
// When the receiver stalls, the output beat holds and the back end freezes;
// the front end keeps taking beats until the queue is committed, then raises
// in_stall. Reset clears all beats in flight, loads the identity matrix and
// the default window (+/-11.0) and viewport (+/-1.0).
module vertex_project_to_canvas #(
	parameter int CANVAS_WIDTH  = 1000,
	parameter int CANVAS_HEIGHT = 1000
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [31:0] cfg_data,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic        action,
	input  wire logic [3:0]  coef_index,
	input  wire logic [31:0] coef_value,
	input  wire logic [31:0] point_x,
	input  wire logic [31:0] point_y,
	input  wire logic [31:0] point_z,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [9:0]       canvas_x,
	output logic [15:0]      canvas_y,
	output logic             divide_fault
);
	import vpc_pkg::*;

	logic [31:0]    cfg_q [8];
	axis_cfg_t      cfg_x, cfg_y;
	logic           push, pop;
	dot_t           push_data, head;
	logic [FCW-1:0] fifo_count;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q[CFG_WIN_MIN_X]  <= -WIN_RST;
			cfg_q[CFG_WIN_MAX_X]  <= WIN_RST;
			cfg_q[CFG_WIN_MIN_Y]  <= -WIN_RST;
			cfg_q[CFG_WIN_MAX_Y]  <= WIN_RST;
			cfg_q[CFG_VIEW_MIN_X] <= -VIEW_RST;
			cfg_q[CFG_VIEW_MAX_X] <= VIEW_RST;
			cfg_q[CFG_VIEW_MIN_Y] <= -VIEW_RST;
			cfg_q[CFG_VIEW_MAX_Y] <= VIEW_RST;
		end else if (cfg_we) begin
			cfg_q[cfg_index] <= cfg_data;
		end
	end

	assign cfg_x.win_min  = cfg_q[CFG_WIN_MIN_X];
	assign cfg_x.win_max  = cfg_q[CFG_WIN_MAX_X];
	assign cfg_x.view_min = cfg_q[CFG_VIEW_MIN_X];
	assign cfg_x.view_max = cfg_q[CFG_VIEW_MAX_X];
	assign cfg_y.win_min  = cfg_q[CFG_WIN_MIN_Y];
	assign cfg_y.win_max  = cfg_q[CFG_WIN_MAX_Y];
	assign cfg_y.view_min = cfg_q[CFG_VIEW_MIN_Y];
	assign cfg_y.view_max = cfg_q[CFG_VIEW_MAX_Y];

	vpc_front u_front (
		.clk, .arst_n, .in_valid, .in_stall, .action, .coef_index, .coef_value,
		.point_x, .point_y, .point_z, .fifo_count, .push, .push_data
	);

	vpc_fifo u_fifo (
		.clk, .arst_n, .push, .push_data, .pop, .head, .count(fifo_count)
	);

	vpc_back #(.CANVAS_WIDTH(CANVAS_WIDTH), .CANVAS_HEIGHT(CANVAS_HEIGHT)) u_back (
		.clk, .arst_n, .fifo_count, .pop, .head, .cfg_x, .cfg_y,
		.out_valid, .out_stall, .canvas_x, .canvas_y, .divide_fault
	);

endmodule
`default_nettype wire

// File: hw/rtl/vpc_div.sv
`timescale 1ns / 1ps
`default_nettype none
module vpc_div #(
	parameter int NW = 8,
	parameter int DW = 8,
	parameter int PW = 1
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          en,
	input  wire logic          in_valid,
	input  wire logic [NW-1:0] num,
	input  wire logic [DW-1:0] den,
	input  wire logic [PW-1:0] pay_in,
	output logic               out_valid,
	output logic [NW-1:0]      quo,
	output logic [PW-1:0]      pay_out
);

	logic [DW-1:0] rem_s [NW+1];
	logic [NW-1:0] nq_s  [NW+1];
	logic [DW-1:0] den_s [NW+1];
	logic [PW-1:0] pay_s [NW+1];
	logic          vld_s [NW+1];

	assign rem_s[0] = '0;
	assign nq_s[0]  = num;
	assign den_s[0] = den;
	assign pay_s[0] = pay_in;
	assign vld_s[0] = in_valid;

	// one quotient bit per stage, numerator shifts out as quotient shifts in
	for (genvar k = 0; k < NW; k++) begin : g_stage
		logic [DW:0] trial;
		logic        ge;

		assign trial = {rem_s[k], nq_s[k][NW-1]};
		assign ge    = trial >= {1'b0, den_s[k]};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else if (en) begin
				vld_s[k+1] <= vld_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k+1] <= ge ? DW'(trial - {1'b0, den_s[k]}) : trial[DW-1:0];
				nq_s[k+1]  <= {nq_s[k][NW-2:0], ge};
				den_s[k+1] <= den_s[k];
				pay_s[k+1] <= pay_s[k];
			end
		end
	end

	assign out_valid = vld_s[NW];
	assign quo       = nq_s[NW];
	assign pay_out   = pay_s[NW];

endmodule
`default_nettype wire

// File: hw/rtl/vpc_front.sv
`timescale 1ns / 1ps
`default_nettype none
module vpc_front (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_stall,
	input  wire logic                 action,
	input  wire logic [3:0]           coef_index,
	input  wire logic [31:0]          coef_value,
	input  wire logic [31:0]          point_x,
	input  wire logic [31:0]          point_y,
	input  wire logic [31:0]          point_z,
	input  wire logic [vpc_pkg::FCW-1:0] fifo_count,
	output logic                      push,
	output vpc_pkg::dot_t             push_data
);
	import vpc_pkg::*;

	logic [31:0]        coef_q [16];
	logic signed [31:0] pt [3];
	logic signed [63:0] prod_s1 [3][3];
	logic signed [31:0] bias_s1 [3];
	logic               valid_s1;
	logic signed [CW-1:0] sum [3];
	dot_t               dot_s2;
	logic               valid_s2;
	logic [FCW:0]       used;
	logic               accept;

	assign pt[0] = $signed(point_x);
	assign pt[1] = $signed(point_y);
	assign pt[2] = $signed(point_z);

	// hold input while queue slots are all spoken for by queued or in-flight points
	assign used     = {1'b0, fifo_count} + (FCW+1)'(valid_s1) + (FCW+1)'(valid_s2);
	assign in_stall = used >= (FCW+1)'(FIFO_DEPTH);
	assign accept   = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 16; i++) begin
				coef_q[i] <= (i % 5 == 0) ? ONE_Q16 : '0;
			end
		end else if (accept && action == ACT_LOAD) begin
			coef_q[coef_index] <= coef_value;
		end
	end

	for (genvar r = 0; r < 3; r++) begin : g_row
		// rows x, y and w; z never reaches an output
		localparam int ROW = (r == 2) ? 3 : r;

		for (genvar c = 0; c < 3; c++) begin : g_col
			always_ff @(posedge clk) begin
				if (accept) begin
					prod_s1[r][c] <= 64'($signed(coef_q[ROW*4+c])) * 64'(pt[c]);
				end
			end
		end

		always_ff @(posedge clk) begin
			if (accept) begin
				bias_s1[r] <= $signed(coef_q[ROW*4+3]);
			end
		end

		assign sum[r] = CW'(prod_s1[r][0] >>> 16) + CW'(prod_s1[r][1] >>> 16)
			+ CW'(prod_s1[r][2] >>> 16) + CW'(bias_s1[r]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= accept && action == ACT_POINT;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		dot_s2.cx <= sum[0];
		dot_s2.cy <= sum[1];
		dot_s2.w  <= sum[2];
	end

	assign push      = valid_s2;
	assign push_data = dot_s2;

endmodule
`default_nettype wire

// File: hw/rtl/vpc_fifo.sv
`timescale 1ns / 1ps
`default_nettype none
module vpc_fifo (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    push,
	input  wire vpc_pkg::dot_t           push_data,
	input  wire logic                    pop,
	output vpc_pkg::dot_t                head,
	output logic [vpc_pkg::FCW-1:0]      count
);
	import vpc_pkg::*;

	dot_t           mem_q [FIFO_DEPTH];
	logic [FPW-1:0] wr_q;
	logic [FPW-1:0] rd_q;
	logic [FCW-1:0] cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= rd_q + 1'b1;
			end
			cnt_q <= cnt_q + FCW'(push) - FCW'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_data;
		end
	end

	assign head  = mem_q[rd_q];
	assign count = cnt_q;

endmodule
`default_nettype wire

// File: hw/rtl/vpc_axis.sv
`timescale 1ns / 1ps
`default_nettype none
module vpc_axis #(
	parameter int SCALE = 1000,
	parameter int SW    = 10,
	parameter bit FLIP  = 1'b0
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    en,
	input  wire logic                    in_valid,
	input  wire logic                    tag_in,
	input  wire logic [vpc_pkg::CW-1:0]  c,
	input  wire logic [vpc_pkg::CW-1:0]  w,
	input  wire vpc_pkg::axis_cfg_t      cfg,
	output logic                         out_valid,
	output logic                         tag_out,
	output logic signed [16:0]           res
);
	import vpc_pkg::*;

	localparam int CNW = SW + 34;
	localparam logic [NAW-1:0] SAT_A = NAW'(1) << 32;

	logic signed [31:0] wmin, wmax, vmin, vmax;
	assign wmin = $signed(cfg.win_min);
	assign wmax = $signed(cfg.win_max);
	assign vmin = $signed(cfg.view_min);
	assign vmax = $signed(cfg.view_max);

	// projection: round(|c| * 2^16 / |w|)
	logic [CW-1:0]  c_mag, w_mag;
	logic [NAW-1:0] num_a, qa;
	logic [1:0]     pay_a;
	logic           va;
	assign c_mag = c[CW-1] ? CW'(-c) : c;
	assign w_mag = w[CW-1] ? CW'(-w) : w;
	assign num_a = {1'b0, c_mag, 16'h0000} + NAW'(w_mag >> 1);

	vpc_div #(.NW(NAW), .DW(CW), .PW(2)) u_div_a (
		.clk, .arst_n, .en, .in_valid,
		.num(num_a), .den(w_mag), .pay_in({tag_in, c[CW-1] ^ w[CW-1]}),
		.out_valid(va), .quo(qa), .pay_out(pay_a)
	);

	logic [32:0]        qs;
	logic signed [33:0] p_s1;
	logic               tag_s1, v_s1;
	assign qs = (qa > SAT_A) ? 33'h1_0000_0000 : qa[32:0];

	// window clamp and spans
	logic signed [33:0] pt, num_w;
	logic signed [32:0] dw, dv;
	always_comb begin
		pt = p_s1;
		if (pt > 34'(wmax)) begin
			pt = 34'(wmax);
		end
		if (pt < 34'(wmin)) begin
			pt = 34'(wmin);
		end
	end
	assign num_w = pt - 34'(wmin);
	assign dw    = 33'(wmax) - 33'(wmin);
	assign dv    = 33'(vmax) - 33'(vmin);

	logic [31:0] num_s2, dw_s2, dw_s3;
	logic [32:0] dvm_s2;
	logic        dvneg_s2, empty_s2, tag_s2, v_s2;
	logic [64:0] prod_s3;
	logic        dvneg_s3, empty_s3, tag_s3, v_s3;

	logic [64:0] num_b, qb;
	logic [2:0]  pay_b;
	logic        vb;
	assign num_b = prod_s3 + 65'(dw_s3 >> 1);

	vpc_div #(.NW(65), .DW(32), .PW(3)) u_div_b (
		.clk, .arst_n, .en, .in_valid(v_s3),
		.num(num_b), .den(dw_s3), .pay_in({tag_s3, empty_s3, dvneg_s3}),
		.out_valid(vb), .quo(qb), .pay_out(pay_b)
	);

	logic signed [34:0] vv, v_s4, vt, e;
	logic signed [32:0] dc;
	logic               tag_s4, v_s4_vld;
	always_comb begin
		if (pay_b[1]) begin
			vv = 35'(vmin);
		end else if (pay_b[0]) begin
			vv = 35'(vmin) - $signed({2'b00, qb[32:0]});
		end else begin
			vv = 35'(vmin) + $signed({2'b00, qb[32:0]});
		end
	end

	// viewport clamp, then offset from the viewport min (negated for y)
	always_comb begin
		vt = v_s4;
		if (vt > 35'(vmax)) begin
			vt = 35'(vmax);
		end
		if (vt < 35'(vmin)) begin
			vt = 35'(vmin);
		end
	end
	assign e  = FLIP ? (-vt - 35'(vmin)) : (vt - 35'(vmin));
	assign dc = 33'(vmax) - 33'(vmin);

	logic [32:0]     em_s5, dm_s5, dm_s6;
	logic            sgn_s5, dz_s5, tag_s5, v_s5;
	logic [SW+32:0]  m_s6;
	logic            sgn_s6, dz_s6, tag_s6, v_s6;

	logic [CNW-1:0] num_c, qc;
	logic [2:0]     pay_c;
	logic           vc;
	assign num_c = CNW'(m_s6) + CNW'(dm_s6 >> 1);

	vpc_div #(.NW(CNW), .DW(33), .PW(3)) u_div_c (
		.clk, .arst_n, .en, .in_valid(v_s6),
		.num(num_c), .den(dm_s6), .pay_in({tag_s6, sgn_s6, dz_s6}),
		.out_valid(vc), .quo(qc), .pay_out(pay_c)
	);

	logic signed [16:0] rr, res_s7;
	logic               tag_s7, v_s7;
	always_comb begin
		if (pay_c[0]) begin
			rr = '0;
		end else if (pay_c[1]) begin
			rr = (qc > CNW'(65536)) ? 17'sh10000 : -$signed({1'b0, qc[15:0]});
			if (qc == CNW'(65536)) begin
				rr = 17'sh10000;
			end
		end else begin
			rr = (qc > CNW'(65535)) ? 17'sh0FFFF : $signed({1'b0, qc[15:0]});
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1     <= 1'b0;
			v_s2     <= 1'b0;
			v_s3     <= 1'b0;
			v_s4_vld <= 1'b0;
			v_s5     <= 1'b0;
			v_s6     <= 1'b0;
			v_s7     <= 1'b0;
		end else if (en) begin
			v_s1     <= va;
			v_s2     <= v_s1;
			v_s3     <= v_s2;
			v_s4_vld <= vb;
			v_s5     <= v_s4_vld;
			v_s6     <= v_s5;
			v_s7     <= vc;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			p_s1     <= pay_a[0] ? -$signed({1'b0, qs}) : $signed({1'b0, qs});
			tag_s1   <= pay_a[1];

			num_s2   <= num_w[31:0];
			dvm_s2   <= dv[32] ? 33'(-dv) : 33'(dv);
			dvneg_s2 <= dv[32];
			dw_s2    <= dw[31:0];
			empty_s2 <= dw <= 33'sd0;
			tag_s2   <= tag_s1;

			prod_s3  <= 65'(num_s2) * 65'(dvm_s2);
			dw_s3    <= dw_s2;
			dvneg_s3 <= dvneg_s2;
			empty_s3 <= empty_s2;
			tag_s3   <= tag_s2;

			v_s4     <= vv;
			tag_s4   <= pay_b[2];

			em_s5    <= e[34] ? 33'(-e) : 33'(e);
			dm_s5    <= dc[32] ? 33'(-dc) : 33'(dc);
			sgn_s5   <= e[34] ^ dc[32];
			dz_s5    <= dc == 33'sd0;
			tag_s5   <= tag_s4;

			m_s6     <= (SW+33)'(SCALE) * (SW+33)'(em_s5);
			dm_s6    <= dm_s5;
			sgn_s6   <= sgn_s5;
			dz_s6    <= dz_s5;
			tag_s6   <= tag_s5;

			res_s7   <= rr;
			tag_s7   <= pay_c[2];
		end
	end

	assign out_valid = v_s7;
	assign tag_out   = tag_s7;
	assign res       = res_s7;

endmodule
`default_nettype wire

// File: hw/rtl/vpc_back.sv
`timescale 1ns / 1ps
`default_nettype none
module vpc_back #(
	parameter int CANVAS_WIDTH  = 1000,
	parameter int CANVAS_HEIGHT = 1000
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic [vpc_pkg::FCW-1:0] fifo_count,
	output logic                         pop,
	input  wire vpc_pkg::dot_t           head,
	input  wire vpc_pkg::axis_cfg_t      cfg_x,
	input  wire vpc_pkg::axis_cfg_t      cfg_y,
	output logic                         out_valid,
	input  wire logic                    out_stall,
	output logic [9:0]                   canvas_x,
	output logic [15:0]                  canvas_y,
	output logic                         divide_fault
);
	import vpc_pkg::*;

	localparam int SMAX = (CANVAS_WIDTH > CANVAS_HEIGHT) ? CANVAS_WIDTH : CANVAS_HEIGHT;
	localparam int SW   = $clog2(SMAX + 1);

	logic               adv;
	logic               valid_s1;
	dot_t               head_s1;
	logic               fault0;
	logic               vx, vy, fx, fy, fault;
	logic signed [16:0] rx, ry;
	logic [9:0]         cx_c;
	logic [15:0]        cy_c;
	logic               out_valid_q, fault_q;
	logic [9:0]         cx_q;
	logic [15:0]        cy_q;

	// advance the whole back pipe unless a finished beat is held
	assign adv = !out_valid_q || !out_stall;
	assign pop = adv && fifo_count != '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			valid_s1    <= fifo_count != '0;
			out_valid_q <= vx && vy;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			head_s1 <= head;
		end
	end

	assign fault0 = head_s1.w == '0;

	vpc_axis #(.SCALE(CANVAS_WIDTH), .SW(SW), .FLIP(1'b0)) u_axis_x (
		.clk, .arst_n, .en(adv), .in_valid(valid_s1), .tag_in(fault0),
		.c(head_s1.cx), .w(head_s1.w), .cfg(cfg_x),
		.out_valid(vx), .tag_out(fx), .res(rx)
	);

	vpc_axis #(.SCALE(CANVAS_HEIGHT), .SW(SW), .FLIP(1'b1)) u_axis_y (
		.clk, .arst_n, .en(adv), .in_valid(valid_s1), .tag_in(fault0),
		.c(head_s1.cy), .w(head_s1.w), .cfg(cfg_y),
		.out_valid(vy), .tag_out(fy), .res(ry)
	);

	assign fault = fx || fy;

	always_comb begin
		if (fault || rx < 17'sd0) begin
			cx_c = '0;
		end else if (rx > 17'sd1023) begin
			cx_c = 10'd1023;
		end else begin
			cx_c = rx[9:0];
		end

		if (fault) begin
			cy_c = '0;
		end else if (ry > 17'sd32767) begin
			cy_c = 16'h7FFF;
		end else if (ry < -17'sd32768) begin
			cy_c = 16'h8000;
		end else begin
			cy_c = ry[15:0];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			cx_q    <= cx_c;
			cy_q    <= cy_c;
			fault_q <= fault;
		end
	end

	assign out_valid    = out_valid_q;
	assign canvas_x     = cx_q;
	assign canvas_y     = cy_q;
	assign divide_fault = fault_q;

endmodule
`default_nettype wire

// File: dv/tb_vertex_project_to_canvas.sv
`timescale 1ns / 1ps
module tb_vertex_project_to_canvas;
	import vpc_pkg::*;

	localparam int  WIDTH_PX  = 1000;
	localparam int  HEIGHT_PX = 1000;
	localparam int  SETTLE    = 200;
	localparam int  LIMIT     = 400000;
	localparam int  PHASES    = 8;
	localparam int  PER_PHASE = 70;

	typedef struct {
		action_t     act;
		logic [3:0]  idx;
		logic [31:0] coef;
		logic [31:0] px;
		logic [31:0] py;
		logic [31:0] pz;
		bit          typed;
		logic [9:0]  ex;
		logic [15:0] ey;
		logic        ef;
	} beat_t;

	typedef struct {
		logic [9:0]  x;
		logic [15:0] y;
		logic        f;
	} pixel_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [2:0]  cfg_index = '0;
	logic [31:0] cfg_data = '0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic        action = 1'b0;
	logic [3:0]  coef_index = '0;
	logic [31:0] coef_value = '0;
	logic [31:0] point_x = '0;
	logic [31:0] point_y = '0;
	logic [31:0] point_z = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [9:0]  canvas_x;
	logic [15:0] canvas_y;
	logic        divide_fault;

	vertex_project_to_canvas #(
		.CANVAS_WIDTH (WIDTH_PX),
		.CANVAS_HEIGHT(HEIGHT_PX)
	) i_dut (
		.clk, .arst_n, .cfg_we, .cfg_index, .cfg_data,
		.in_valid, .in_stall, .action, .coef_index, .coef_value,
		.point_x, .point_y, .point_z,
		.out_valid, .out_stall, .canvas_x, .canvas_y, .divide_fault
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// shadow state of the block
	logic signed [31:0] mat [16];
	logic signed [31:0] bound [8];
	pixel_t pixel_q [$];
	int errors = 0;
	int cycles = 0;
	bit calm = 1'b0;

	task automatic report(string what, longint got, longint want);
		$display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
		errors++;
	endtask

	function automatic logic [127:0] mag(longint v);
		return (v < 0) ? 128'(-v) : 128'(v);
	endfunction

	function automatic logic [127:0] udiv_rnd(logic [127:0] n, logic [127:0] d);
		return (n + d / 2) / d;
	endfunction

	function automatic longint sdiv_rnd(longint num, longint den);
		longint q;
		q = longint'(udiv_rnd(mag(num), mag(den)));
		return ((num < 0) != (den < 0)) ? -q : q;
	endfunction

	function automatic longint clamp(longint v, longint lo, longint hi);
		if (v > hi) v = hi;
		if (v < lo) v = lo;
		return v;
	endfunction

	function automatic longint row_dot(int r, longint x, longint y, longint z);
		return ((longint'(mat[r*4]) * x) >>> 16) + ((longint'(mat[r*4+1]) * y) >>> 16)
			+ ((longint'(mat[r*4+2]) * z) >>> 16) + longint'(mat[r*4+3]);
	endfunction

	function automatic longint divide_by_w(longint c, longint w);
		logic [127:0] q;
		q = udiv_rnd(mag(c) << 16, mag(w));
		if (q > (128'd1 << 32)) q = 128'd1 << 32;
		return ((c < 0) != (w < 0)) ? -longint'(q) : longint'(q);
	endfunction

	function automatic longint window_to_view(longint p, longint wmin, longint wmax,
			longint vmin, longint vmax);
		longint dw, num, dv, q;
		p = clamp(p, wmin, wmax);
		dw = wmax - wmin;
		if (dw == 0) return vmin;
		num = p - wmin;
		dv = vmax - vmin;
		q = longint'(udiv_rnd(mag(num) * mag(dv), mag(dw)));
		if (((num < 0) != (dv < 0)) != (dw < 0)) return vmin - q;
		return vmin + q;
	endfunction

	function automatic pixel_t project_point(logic [31:0] px, logic [31:0] py,
			logic [31:0] pz);
		longint x, y, z, cx, cy, w, vx, vy, d, ox, oy;
		pixel_t r;
		x = longint'($signed(px));
		y = longint'($signed(py));
		z = longint'($signed(pz));
		cx = row_dot(0, x, y, z);
		cy = row_dot(1, x, y, z);
		w = row_dot(3, x, y, z);
		r = '{x: '0, y: '0, f: 1'b1};
		if (w == 0) return r;
		vx = window_to_view(divide_by_w(cx, w), bound[CFG_WIN_MIN_X], bound[CFG_WIN_MAX_X],
			bound[CFG_VIEW_MIN_X], bound[CFG_VIEW_MAX_X]);
		vy = window_to_view(divide_by_w(cy, w), bound[CFG_WIN_MIN_Y], bound[CFG_WIN_MAX_Y],
			bound[CFG_VIEW_MIN_Y], bound[CFG_VIEW_MAX_Y]);
		vx = clamp(vx, bound[CFG_VIEW_MIN_X], bound[CFG_VIEW_MAX_X]);
		vy = clamp(vy, bound[CFG_VIEW_MIN_Y], bound[CFG_VIEW_MAX_Y]);
		ox = 0;
		oy = 0;
		d = longint'(bound[CFG_VIEW_MAX_X]) - bound[CFG_VIEW_MIN_X];
		if (d != 0)
			ox = clamp(sdiv_rnd(WIDTH_PX * (vx - bound[CFG_VIEW_MIN_X]), d), 0, 1023);
		d = longint'(bound[CFG_VIEW_MAX_Y]) - bound[CFG_VIEW_MIN_Y];
		if (d != 0)
			oy = clamp(sdiv_rnd(HEIGHT_PX * (-vy - bound[CFG_VIEW_MIN_Y]), d),
				-32768, 32767);
		r.x = ox[9:0];
		r.y = oy[15:0];
		r.f = 1'b0;
		return r;
	endfunction

	function automatic logic [31:0] pick32();
		case ($urandom_range(0, 9))
			0, 1:    return $urandom;
			2:       return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
			3:       return 32'(int'($urandom_range(0, 4)) - 2) << 16;
			default: return 32'(int'($urandom_range(0, 32'h0020_0000)) - 32'h0010_0000);
		endcase
	endfunction

	function automatic beat_t mk(action_t a, logic [3:0] i, logic [31:0] c, logic [31:0] x,
			logic [31:0] y, logic [31:0] z, bit t = 1'b0, logic [9:0] ex = '0,
			logic [15:0] ey = '0, logic ef = 1'b0);
		return '{act: a, idx: i, coef: c, px: x, py: y, pz: z, typed: t,
			ex: ex, ey: ey, ef: ef};
	endfunction

	task automatic send(beat_t b);
		while (!calm && $urandom_range(0, 99) < 23) begin
			@(negedge clk);
			in_valid <= 1'b0;
		end
		@(negedge clk);
		action <= b.act;
		coef_index <= b.idx;
		coef_value <= b.coef;
		point_x <= b.px;
		point_y <= b.py;
		point_z <= b.pz;
		in_valid <= 1'b1;
		do @(posedge clk); while (in_stall);
		if (b.act == ACT_LOAD)
			mat[b.idx] = b.coef;
		else if (b.typed)
			pixel_q.push_back('{x: b.ex, y: b.ey, f: b.ef});
		else
			pixel_q.push_back(project_point(b.px, b.py, b.pz));
	endtask

	task automatic cfg_write(cfg_idx_t idx, logic [31:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		bound[idx] = val;
	endtask

	task automatic drain();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pixel_q.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	always @(negedge clk)
		out_stall <= !calm && ($urandom_range(0, 99) < 23);

	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT) begin
			$display("[vertex_project_to_canvas] ERROR");
			$finish;
		end
	end

	always @(posedge clk) begin
		pixel_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pixel_q.size() == 0) begin
				report("unexpected beat", canvas_x, 0);
			end else begin
				want = pixel_q.pop_front();
				if (canvas_x !== want.x) report("canvas_x", canvas_x, want.x);
				if (canvas_y !== want.y)
					report("canvas_y", $signed(canvas_y), $signed(want.y));
				if (divide_fault !== want.f) report("divide_fault", divide_fault, want.f);
			end
		end
	end

	initial begin
		beat_t tab [$];
		logic [31:0] cfg [8];
		for (int i = 0; i < 16; i++) mat[i] = (i % 5 == 0) ? ONE_Q16 : '0;
		bound[CFG_WIN_MIN_X] = -WIN_RST;
		bound[CFG_WIN_MAX_X] = WIN_RST;
		bound[CFG_WIN_MIN_Y] = -WIN_RST;
		bound[CFG_WIN_MAX_Y] = WIN_RST;
		bound[CFG_VIEW_MIN_X] = -VIEW_RST;
		bound[CFG_VIEW_MAX_X] = VIEW_RST;
		bound[CFG_VIEW_MIN_Y] = -VIEW_RST;
		bound[CFG_VIEW_MAX_Y] = VIEW_RST;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// origin lands mid canvas; window edges and extremes hit the borders
		tab.push_back(mk(ACT_POINT, 4'hF, 32'hFFFF_FFFF, 0, 0, 0, 1, 10'd500, 16'd500));
		tab.push_back(mk(ACT_POINT, 0, 0, WIN_RST, WIN_RST, 0, 1, 10'd1000, 16'd0));
		tab.push_back(mk(ACT_POINT, 0, 0, -WIN_RST, -WIN_RST, 0, 1, 10'd0, 16'd1000));
		tab.push_back(mk(ACT_POINT, 0, 0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
			1, 10'd1000, 16'd0));
		tab.push_back(mk(ACT_POINT, 0, 0, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
			1, 10'd0, 16'd1000));
		tab.push_back(mk(ACT_POINT, 0, 0, 32'h0001_8000, 32'hFFFE_8000, 32'h1234_5678));
		// point fields ride along with loads and are ignored
		tab.push_back(mk(ACT_LOAD, 4'd0, 32'h0002_0000, $urandom, $urandom, $urandom));
		tab.push_back(mk(ACT_LOAD, 4'd2, 32'h8000_0000, 0, 0, 0));
		tab.push_back(mk(ACT_POINT, 0, 0, 32'h0003_0000, 32'h0000_4000, 32'h0000_0001));
		tab.push_back(mk(ACT_LOAD, 4'd15, 32'h0000_0000, 0, 0, 0));
		tab.push_back(mk(ACT_POINT, 0, 0, 32'h0005_0000, 32'h0006_0000, 0, 1, 10'd0,
			16'd0, 1'b1));
		tab.push_back(mk(ACT_LOAD, 4'd15, 32'hFFFF_0000, 0, 0, 0));
		tab.push_back(mk(ACT_POINT, 0, 0, 32'h0002_0000, 32'h0007_0000, 32'hFFFF_0000));
		tab.push_back(mk(ACT_LOAD, 4'd12, 32'h0000_0100, 0, 0, 0));
		tab.push_back(mk(ACT_POINT, 0, 0, 32'h0100_0000, 32'h0000_0001, 0));
		tab.push_back(mk(ACT_LOAD, 4'd5, 32'h7FFF_FFFF, 0, 0, 0));
		tab.push_back(mk(ACT_POINT, 0, 0, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000));
		tab.push_back(mk(ACT_LOAD, 4'd12, 32'h0000_0000, 0, 0, 0));
		tab.push_back(mk(ACT_LOAD, 4'd15, 32'h0001_0000, 0, 0, 0));
		tab.push_back(mk(ACT_POINT, 0, 0, 32'h0000_0001, 32'hFFFF_FFFF, 0));
		foreach (tab[i]) send(tab[i]);

		for (int ph = 0; ph < PHASES; ph++) begin
			drain();
			calm = (ph == 3);
			for (int r = 0; r < 8; r++) cfg[r] = bound[r];
			case (ph)
				0: begin
					for (int r = 0; r < 4; r++)
						cfg[r] = (r % 2) ? ($urandom_range(1, 40) << 16)
							: -($urandom_range(1, 40) << 16);
					for (int r = 4; r < 8; r++)
						cfg[r] = (r % 2) ? ($urandom_range(1, 4) << 16)
							: -($urandom_range(1, 4) << 16);
				end
				1: for (int r = 0; r < 8; r++) cfg[r] = (r % 2) ? 32'h7FFF_FFFF : 32'h8000_0000;
				2: begin
					// min above max pins the window to its min
					cfg[CFG_WIN_MIN_X] = 32'h0005_0000;
					cfg[CFG_WIN_MAX_X] = 32'hFFFB_0000;
					cfg[CFG_WIN_MIN_Y] = 32'hFFF6_0000;
					cfg[CFG_WIN_MAX_Y] = 32'h000A_0000;
					cfg[CFG_VIEW_MIN_X] = 32'hFFFF_0000;
					cfg[CFG_VIEW_MAX_X] = 32'h0001_0000;
				end
				3: begin
					cfg[CFG_WIN_MIN_X] = 32'h0003_0000;
					cfg[CFG_WIN_MAX_X] = 32'h0003_0000;
					cfg[CFG_VIEW_MIN_Y] = 32'h0000_8000;
					cfg[CFG_VIEW_MAX_Y] = 32'h0000_8000;
				end
				4: begin
					cfg[CFG_WIN_MAX_X] = 32'h000B_0000;
					cfg[CFG_VIEW_MIN_X] = 32'h0002_0000;
					cfg[CFG_VIEW_MAX_X] = 32'hFFFE_0000;
					cfg[CFG_VIEW_MIN_Y] = 32'h0001_0000;
					cfg[CFG_VIEW_MAX_Y] = 32'hFFFF_0000;
				end
				5, 6: for (int r = 0; r < 8; r++) cfg[r] = pick32();
				default: begin
					cfg[CFG_WIN_MIN_X] = -WIN_RST;
					cfg[CFG_WIN_MAX_X] = WIN_RST;
					cfg[CFG_WIN_MIN_Y] = -WIN_RST;
					cfg[CFG_WIN_MAX_Y] = WIN_RST;
					cfg[CFG_VIEW_MIN_X] = -VIEW_RST;
					cfg[CFG_VIEW_MAX_X] = VIEW_RST;
					cfg[CFG_VIEW_MIN_Y] = -VIEW_RST;
					cfg[CFG_VIEW_MAX_Y] = VIEW_RST;
				end
			endcase
			for (int r = 0; r < 8; r++) cfg_write(cfg_idx_t'(r), cfg[r]);
			@(negedge clk);
			cfg_we <= 1'b0;
			for (int n = 0; n < PER_PHASE; n++) begin
				if ($urandom_range(0, 99) < 30)
					send(mk(ACT_LOAD, 4'($urandom), pick32(), $urandom, $urandom, $urandom));
				else
					send(mk(ACT_POINT, 4'($urandom), $urandom, pick32(), pick32(), pick32()));
			end
		end
		drain();

		if (errors == 0)
			$display("[vertex_project_to_canvas] OK");
		else
			$display("[vertex_project_to_canvas] ERROR");
		$finish;
	end

endmodule
